FILE: hdl/mgsp_pkg.sv
`default_nettype none

package mgsp_pkg;

	localparam int GUID_BYTES = 16;
	localparam int MARKER_LEN = 8;

	// input opcodes
	localparam logic OP_STREAM = 1'b0;
	localparam logic OP_TABLE  = 1'b1;

	// table word select codes
	localparam logic [1:0] WSEL_FIND_LO = 2'd0;
	localparam logic [1:0] WSEL_FIND_HI = 2'd1;
	localparam logic [1:0] WSEL_REPL_LO = 2'd2;
	localparam logic [1:0] WSEL_REPL_HI = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER_PATTERN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BYTES     = 2'd2;

	localparam logic [3:0]  PAIR_COUNT_RESET = 4'd0;
	localparam logic [63:0] MARKER_RESET     = 64'h4556_4E54_4556_5442;
	localparam logic [3:0]  SKIP_RESET       = 4'd4;

	// stream scan phases
	localparam logic [1:0] PH_SEARCH  = 2'd0;
	localparam logic [1:0] PH_SKIP    = 2'd1;
	localparam logic [1:0] PH_CAPTURE = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       guid;
		logic       repl;
		logic       last;
	} out_word_t;

endpackage

`default_nettype wire

FILE: hdl/marker_guid_stream_patcher.sv
`default_nettype none

// Marker-triggered GUID patcher. Stream words (opcode 0) pass through one per
// cycle, unless the output stalls or the sequencer is busy, while the block
// hunts for the eight-byte marker; after the marker, skip_bytes words pass
// through, then sixteen words are held as a GUID. The GUID is compared
// against find/replace pairs 0..pair_count-1, with pair_count clamped to
// MAX_PAIRS (last match wins), and goes out as a run of sixteen words,
// replaced on a hit. Table writes (opcode 1) and GUID capture words produce
// no output. The word that completes a GUID starts a sequence: one
// find-memory read per pair in play, a compare of the last read, leaving the
// scan, one replace-memory read, then sixteen output words, one word per
// cycle through the single output register unless the output stalls. Input
// stalls during that sequence. Table memories need no clearing after reset;
// read only entries you wrote.
module marker_guid_stream_patcher
	import mgsp_pkg::*;
#(
	parameter int MAX_PAIRS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// configuration write channel
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [63:0]           cfg_data,
	// input word channel
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  opcode,
	input  wire [7:0]            data_byte,
	input  wire [2:0]            entry_index,
	input  wire [1:0]            word_select,
	input  wire [63:0]           word_value,
	// output word channel
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [7:0]           out_byte,
	output logic                 is_guid_byte,
	output logic                 was_replaced,
	output logic                 last_of_run
);

	localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

	// sequencer states
	localparam logic [1:0] S_RUN  = 2'd0; // take input words
	localparam logic [1:0] S_SCAN = 2'd1; // walk the find table
	localparam logic [1:0] S_REP  = 2'd2; // fetch the winning replace entry
	localparam logic [1:0] S_EMIT = 2'd3; // send the sixteen-word run

	// configuration registers
	logic [3:0]  pair_count_q;
	logic [63:0] marker_q;
	logic [3:0]  skip_q;

	// stream state
	logic [1:0]   st_q;
	logic [1:0]   phase_q;
	logic [3:0]   pcnt_q;
	logic [2:0]   match_q;
	logic [127:0] guid_q;

	// table scan
	logic [AW:0]   scan_q;
	logic [AW:0]   lim;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          hit_q;
	logic [AW-1:0] best_q;
	logic [3:0]    emit_q;

	// table memories, one write port, one registered read port each;
	// low half in bits 63..0, high half in bits 127..64
	logic [127:0] find_mem [MAX_PAIRS];
	logic [127:0] repl_mem [MAX_PAIRS];
	logic [127:0] fd_rd_q;
	logic [127:0] rp_rd_q;

	// output register
	out_word_t out_q;
	out_word_t out_next;
	logic      out_valid_q;
	logic      out_free;
	logic      out_load;

	logic          in_acc;
	logic          stream_acc;
	logic          tbl_we;
	logic [AW-1:0] waddr;
	logic          scan_rd;
	logic [4:0]    pcnt_inc;
	logic [2:0]    want_sel;
	logic [7:0]    want_byte;
	logic [7:0]    emit_byte;

	// Output slot frees up when it is empty or its word leaves this edge.
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = !((st_q == S_RUN) && out_free);
	assign in_acc     = in_valid && !in_stall;
	assign stream_acc = in_acc && (opcode == OP_STREAM);
	// Drop writes to pairs beyond the table.
	assign tbl_we     = in_acc && (opcode == OP_TABLE) && (int'(entry_index) < MAX_PAIRS);
	assign waddr      = AW'(entry_index);

	assign cfg_ready  = 1'b1;

	// Pair count is clamped to the table depth.
	assign lim     = (int'(pair_count_q) > MAX_PAIRS) ? (AW+1)'(MAX_PAIRS)
	                                                  : (AW+1)'(pair_count_q);
	assign scan_rd = (st_q == S_SCAN) && (scan_q < lim);

	assign pcnt_inc  = {1'b0, pcnt_q} + 5'd1;
	// First expected marker byte sits in the top byte of the pattern.
	assign want_sel  = 3'(MARKER_LEN - 1) - match_q;
	assign want_byte = marker_q[{want_sel, 3'b000} +: 8];

	assign emit_byte = hit_q ? rp_rd_q[{emit_q, 3'b000} +: 8]
	                         : guid_q[{emit_q, 3'b000} +: 8];

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= PAIR_COUNT_RESET;
			marker_q     <= MARKER_RESET;
			skip_q       <= SKIP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_PAIR_COUNT) pair_count_q <= cfg_data[3:0];
			if (cfg_index == CFG_MARKER_PATTERN) marker_q <= cfg_data;
			if (cfg_index == CFG_SKIP_BYTES) skip_q <= cfg_data[3:0];
		end
	end

	// Table memory write port.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			unique case (word_select)
				WSEL_FIND_LO: find_mem[waddr][63:0]   <= word_value;
				WSEL_FIND_HI: find_mem[waddr][127:64] <= word_value;
				WSEL_REPL_LO: repl_mem[waddr][63:0]   <= word_value;
				WSEL_REPL_HI: repl_mem[waddr][127:64] <= word_value;
			endcase
		end
	end

	// Table memory read ports. Writes only happen in S_RUN and reads only
	// in S_SCAN and S_REP, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (scan_rd)
			fd_rd_q <= find_mem[scan_q[AW-1:0]];
		if (st_q == S_REP)
			rp_rd_q <= repl_mem[best_q];
	end

	// GUID hold register, one byte per capture word; byte i at bits 8i+7..8i.
	always_ff @(posedge clk) begin
		if (stream_acc && (phase_q == PH_CAPTURE))
			guid_q[{pcnt_q, 3'b000} +: 8] <= data_byte;
	end

	// Sequencer and stream scanner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_RUN;
			phase_q   <= PH_SEARCH;
			pcnt_q    <= '0;
			match_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			hit_q     <= 1'b0;
			best_q    <= '0;
			emit_q    <= '0;
		end else begin
			unique case (st_q)
				S_RUN: begin
					if (stream_acc) begin
						unique case (phase_q)
							PH_CAPTURE: begin
								if (pcnt_q == 4'(GUID_BYTES - 1)) begin
									// GUID complete: rearm the marker search, start the scan
									pcnt_q    <= '0;
									phase_q   <= PH_SEARCH;
									match_q   <= '0;
									st_q      <= S_SCAN;
									scan_q    <= '0;
									rd_vld_s1 <= 1'b0;
									hit_q     <= 1'b0;
								end else begin
									pcnt_q <= pcnt_inc[3:0];
								end
							end
							PH_SKIP: begin
								// a lowered skip count ends the skip at once
								if (pcnt_inc >= {1'b0, skip_q}) begin
									pcnt_q  <= '0;
									phase_q <= PH_CAPTURE;
								end else begin
									pcnt_q <= pcnt_inc[3:0];
								end
							end
							PH_SEARCH: begin
								if (data_byte == want_byte) begin
									if (match_q == 3'(MARKER_LEN - 1)) begin
										match_q <= '0;
										pcnt_q  <= '0;
										phase_q <= (skip_q == 4'd0) ? PH_CAPTURE : PH_SKIP;
									end else begin
										match_q <= match_q + 3'd1;
									end
								end else begin
									// mismatch: restart, do not retry this byte
									match_q <= '0;
								end
							end
							default: phase_q <= PH_SEARCH;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_rd) begin
						scan_q    <= scan_q + (AW+1)'(1);
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= scan_q[AW-1:0];
					end else begin
						rd_vld_s1 <= 1'b0;
						if (!rd_vld_s1) st_q <= S_REP;
					end
					// later pairs override earlier hits
					if (rd_vld_s1 && (fd_rd_q == guid_q)) begin
						hit_q  <= 1'b1;
						best_q <= rd_idx_s1;
					end
				end
				S_REP: begin
					st_q   <= S_EMIT;
					emit_q <= '0;
				end
				S_EMIT: begin
					if (out_free) begin
						emit_q <= emit_q + 4'd1;
						if (emit_q == 4'(GUID_BYTES - 1)) st_q <= S_RUN;
					end
				end
				default: st_q <= S_RUN;
			endcase
		end
	end

	// Output word selection: pass-through byte or next byte of the run.
	always_comb begin
		out_load = 1'b0;
		out_next = '{data: data_byte, guid: 1'b0, repl: 1'b0, last: 1'b1};
		if (stream_acc && (phase_q != PH_CAPTURE)) out_load = 1'b1;
		if ((st_q == S_EMIT) && out_free) begin
			out_load = 1'b1;
			out_next = '{data: emit_byte, guid: 1'b1, repl: hit_q,
			             last: (emit_q == 4'(GUID_BYTES - 1))};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_next;
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_q.data;
	assign is_guid_byte = out_q.guid;
	assign was_replaced = out_q.repl;
	assign last_of_run  = out_q.last;

	// The scan always starts from a rearmed marker search.
	a_scan_rearmed: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN) |-> (phase_q == PH_SEARCH && pcnt_q == 4'd0 && match_q == 3'd0))
		else $error("scan running with stream state not rearmed");

	// Find reads are only in flight while scanning.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (st_q == S_SCAN))
		else $error("find read data outside the scan");

	// No input word is taken while the sequencer is busy.
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_RUN) |-> in_stall)
		else $error("input not stalled while sequencer busy");

	// Every emit step lands a GUID word in the output register.
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT && out_free) |=> (out_valid_q && out_q.guid))
		else $error("emit step did not load a GUID word");

endmodule

`default_nettype wire
